/* src/slppe_pkg.sv */
// ----------------------------------------------------------------------------
// slppe_pkg
// Shared types and constants for the scanline palette pixel expander.
// ----------------------------------------------------------------------------
package slppe_pkg;

  // pixel bytes expanded per line before further bytes are dropped
  localparam int BYTES_PER_LINE = 160;
  localparam int LINE_CNT_W     = $clog2(BYTES_PER_LINE + 1);

  localparam int PAL_DEPTH  = 16;
  localparam int PAL_IDX_W  = 4;
  localparam int COLOUR_W   = 12;

  typedef logic [1:0]            cmd_t;
  typedef logic [COLOUR_W-1:0]   colour_t;
  typedef logic [PAL_IDX_W-1:0]  pal_idx_t;
  typedef logic [2:0]            pix_count_t;

  localparam cmd_t CMD_LINE  = 2'd0;
  localparam cmd_t CMD_LOAD  = 2'd1;
  localparam cmd_t CMD_PIXEL = 2'd2;

  localparam int CTL_WIDE_BIT = 7;
  localparam int CTL_FILL_BIT = 5;

  // palette groups used by the four pixels in 640 mode
  localparam pal_idx_t GRP_A = 4'h8;
  localparam pal_idx_t GRP_B = 4'hc;
  localparam pal_idx_t GRP_C = 4'h0;
  localparam pal_idx_t GRP_D = 4'h4;

  localparam pix_count_t COUNT_WIDE   = 3'd4;
  localparam pix_count_t COUNT_NARROW = 3'd2;

endpackage

/* src/scanline_palette_pixel_expander.sv */
// ----------------------------------------------------------------------------
// scanline_palette_pixel_expander
// Expands video bytes into 12-bit palette colours, 320 or 640 mode, with fill.
// ----------------------------------------------------------------------------
// A pixel byte is taken into the input register at the accepting edge, then looked up
// in the palette into the result register, which offers its result. Throughput: one
// transaction per cycle while the output does not stall; the result register decouples
// the output stall, so the input register still takes a transaction while a result
// waits, unless it holds a pixel byte that would produce a result. Reset clears the valid
// bits, the mode bits and the line byte counter; the palette is not reset and reads undefined until written.
module scanline_palette_pixel_expander
  import slppe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_command,
  input  logic [7:0]           in_line_control,
  input  logic [3:0]           in_palette_index,
  input  logic [11:0]          in_colour_value,
  input  logic [7:0]           in_pixel_byte,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [11:0]          out_pixel_a,
  output logic [11:0]          out_pixel_b,
  output logic [11:0]          out_pixel_c,
  output logic [11:0]          out_pixel_d,
  output logic [2:0]           out_pixel_count
);

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  cmd_t       s1_cmd_r;
  logic [7:0] s1_ctl_r;
  pal_idx_t   s1_idx_r;
  colour_t    s1_colour_r;
  logic [7:0] s1_byte_r;

  // block state
  colour_t               pal_r [PAL_DEPTH];
  colour_t               pal_nxt [PAL_DEPTH];
  logic                  wide_r, wide_nxt;
  logic                  fill_r, fill_nxt;
  logic [LINE_CNT_W-1:0] line_cnt_r, line_cnt_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  colour_t    pix_a_r, pix_b_r, pix_c_r, pix_d_r;
  colour_t    pix_a_nxt, pix_b_nxt, pix_c_nxt, pix_d_nxt;
  pix_count_t count_r, count_nxt;

  logic in_acc;
  logic out_free;
  logic s1_produce;
  logic s1_go;

  colour_t pal_w [PAL_DEPTH];
  colour_t col_a, col_b, col_c, col_d;

  assign out_free   = !out_valid_r || !out_stall;
  assign s1_produce = (s1_cmd_r == CMD_PIXEL) &&
                      (line_cnt_r < LINE_CNT_W'(BYTES_PER_LINE));
  assign s1_go      = s1_valid_r && (!s1_produce || out_free);
  assign in_stall   = s1_valid_r && !s1_go;
  assign in_acc     = in_valid && !in_stall;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = (s1_go && s1_produce) ? 1'b1 : (out_valid_r && out_stall);

  // pixel lookup with fill write-back chained through the pixels in order
  always_comb begin
    pal_w = pal_r;
    col_a = '0;
    col_b = '0;
    col_c = '0;
    col_d = '0;
    if (wide_r) begin
      col_a = pal_w[GRP_A | {2'b00, s1_byte_r[7:6]}];
      if (fill_r) pal_w[GRP_B] = col_a;
      col_b = pal_w[GRP_B | {2'b00, s1_byte_r[5:4]}];
      if (fill_r) pal_w[GRP_C] = col_b;
      col_c = pal_w[GRP_C | {2'b00, s1_byte_r[3:2]}];
      if (fill_r) pal_w[GRP_D] = col_c;
      col_d = pal_w[GRP_D | {2'b00, s1_byte_r[1:0]}];
      if (fill_r) pal_w[GRP_A] = col_d;
    end else begin
      col_a = pal_w[s1_byte_r[7:4]];
      if (fill_r) pal_w[GRP_C] = col_a;
      col_b = pal_w[s1_byte_r[3:0]];
      if (fill_r) pal_w[GRP_C] = col_b;
    end
  end

  always_comb begin
    pal_nxt      = pal_r;
    wide_nxt     = wide_r;
    fill_nxt     = fill_r;
    line_cnt_nxt = line_cnt_r;
    pix_a_nxt    = pix_a_r;
    pix_b_nxt    = pix_b_r;
    pix_c_nxt    = pix_c_r;
    pix_d_nxt    = pix_d_r;
    count_nxt    = count_r;
    if (s1_go) begin
      unique case (s1_cmd_r)
        CMD_LINE: begin
          wide_nxt     = s1_ctl_r[CTL_WIDE_BIT];
          fill_nxt     = s1_ctl_r[CTL_FILL_BIT];
          line_cnt_nxt = '0;
        end
        CMD_LOAD: begin
          pal_nxt[s1_idx_r] = s1_colour_r;
        end
        CMD_PIXEL: begin
          if (s1_produce) begin
            pal_nxt      = pal_w;
            line_cnt_nxt = line_cnt_r + 1'b1;
            pix_a_nxt    = col_a;
            pix_b_nxt    = col_b;
            pix_c_nxt    = wide_r ? col_c : '0;
            pix_d_nxt    = wide_r ? col_d : '0;
            count_nxt    = wide_r ? COUNT_WIDE : COUNT_NARROW;
          end
        end
        default: begin
          // unknown command, dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      wide_r      <= 1'b0;
      fill_r      <= 1'b0;
      line_cnt_r  <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      wide_r      <= wide_nxt;
      fill_r      <= fill_nxt;
      line_cnt_r  <= line_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r    <= in_command;
      s1_ctl_r    <= in_line_control;
      s1_idx_r    <= in_palette_index;
      s1_colour_r <= in_colour_value;
      s1_byte_r   <= in_pixel_byte;
    end
    pal_r   <= pal_nxt;
    pix_a_r <= pix_a_nxt;
    pix_b_r <= pix_b_nxt;
    pix_c_r <= pix_c_nxt;
    pix_d_r <= pix_d_nxt;
    count_r <= count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_a     = pix_a_r;
  assign out_pixel_b     = pix_b_r;
  assign out_pixel_c     = pix_c_r;
  assign out_pixel_d     = pix_d_r;
  assign out_pixel_count = count_r;

  // a pixel byte past the end of the line must not create a result
  a_line_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_cmd_r == CMD_PIXEL && line_cnt_r == LINE_CNT_W'(BYTES_PER_LINE))
    |=> (out_valid_r == $past(out_valid_r && out_stall)))
    else $error("pixel byte beyond line length produced a result");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_cnt_r <= LINE_CNT_W'(BYTES_PER_LINE))
    else $error("line byte counter overran");

  a_count_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (count_r == COUNT_WIDE || count_r == COUNT_NARROW))
    else $error("bad pixel count");

  a_narrow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && count_r == COUNT_NARROW) |-> (pix_c_r == '0 && pix_d_r == '0))
    else $error("320 mode result has nonzero upper pixels");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_produce && out_valid_r))
    else $error("input stalled with no pending work");

endmodule
